>>> rtl/core/dnc_pkg.sv
package dnc_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_TALLY_BITS = 32;
    localparam int NUM_BITS       = 32;
    localparam int COUNT_BITS     = 32;

    // Status of the divisor search toward the output stage
    typedef struct packed {
        logic idle;
        logic valid;
        logic deficient;
        logic last;
    } t_seq_stat;

endpackage

>>> rtl/core/dnc_divider.sv
module dnc_divider #(
    parameter int VALUE_BITS = dnc_pkg::DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [VALUE_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [VALUE_BITS-1:0] o_remainder
);
    import dnc_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_quo;
    logic [VALUE_BITS-1:0] r_div;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [VALUE_BITS:0]   w_shift;
    logic [VALUE_BITS:0]   w_trial;

    // one quotient bit per cycle, restoring form
    assign w_shift = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_trial = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!w_trial[VALUE_BITS]) begin
                r_rem <= w_trial[VALUE_BITS-1:0];
                r_quo <= {r_quo[VALUE_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[VALUE_BITS-1:0];
                r_quo <= {r_quo[VALUE_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> rtl/core/dnc_seq.sv
module dnc_seq #(
    parameter int VALUE_BITS = dnc_pkg::DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_number,
    input  logic                  i_last,
    input  logic                  i_take,
    input  logic                  i_div_done,
    input  logic [VALUE_BITS-1:0] i_quotient,
    input  logic [VALUE_BITS-1:0] i_remainder,
    output logic                  o_div_start,
    output logic [VALUE_BITS-1:0] o_dividend,
    output logic [VALUE_BITS-1:0] o_divisor,
    output dnc_pkg::t_seq_stat    o_stat
);
    import dnc_pkg::*;

    localparam int SW = VALUE_BITS + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAUNCH = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_ADDQ   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_n, n_n;
    logic [VALUE_BITS-1:0] r_i, n_i;
    logic [SW-1:0]         r_sum, n_sum;
    logic                  r_def, n_def;
    logic                  r_last, n_last;
    logic [SW-1:0]         w_sum_q;

    assign w_sum_q = r_sum + ((i_quotient != r_i) ? {1'b0, i_quotient} : SW'(0));

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_sum       = r_sum;
        n_def       = r_def;
        n_last      = r_last;
        o_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_n    = i_number;
                    n_last = i_last;
                    if (i_number == '0 || i_number[VALUE_BITS-1]) begin
                        n_def   = 1'b0;
                        n_state = S_RESULT;
                    end else begin
                        n_sum   = (i_number > VALUE_BITS'(1)) ? SW'(1) : SW'(0);
                        n_i     = VALUE_BITS'(2);
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH: begin
                o_div_start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (i_div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // quotient below divisor means divisor squared exceeds n
                if (i_quotient < r_i) begin
                    n_def   = (r_sum < {1'b0, r_n});
                    n_state = S_RESULT;
                end else if (i_remainder == '0) begin
                    n_sum   = r_sum + {1'b0, r_i};
                    n_state = S_ADDQ;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_LAUNCH;
                end
            end
            S_ADDQ: begin
                // stop early once the sum reaches the value
                if (w_sum_q >= {1'b0, r_n}) begin
                    n_def   = 1'b0;
                    n_state = S_RESULT;
                end else begin
                    n_sum   = w_sum_q;
                    n_i     = r_i + 1'b1;
                    n_state = S_LAUNCH;
                end
            end
            S_RESULT: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_i    <= n_i;
        r_sum  <= n_sum;
        r_def  <= n_def;
        r_last <= n_last;
    end

    assign o_dividend       = r_n;
    assign o_divisor        = r_i;
    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.valid     = (r_state == S_RESULT);
    assign o_stat.deficient = r_def;
    assign o_stat.last      = r_last;

endmodule

>>> rtl/core/deficient_number_counter.sv
// Each trial divisor is launched, awaited and checked, with an add step when it divides n,
//   for divisors 2 up to floor(sqrt(n)) + 1 or until the divisor sum reaches n, then to the output.
// One item is taken at a time; zero and negative values skip the divisor search.
//   The one-bit-per-cycle divider sets the pace.
// A finished result waits in the output register while the next item is worked on.
// Reset: synchronous, active low; clears the sequencer, output valid and group tally.
module deficient_number_counter #(
    parameter int VALUE_BITS = dnc_pkg::DEF_VALUE_BITS,
    parameter int TALLY_BITS = dnc_pkg::DEF_TALLY_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dnc_pkg::NUM_BITS-1:0]    s_axis_tdata,  // [31:0] number
    input  logic                            s_axis_tlast,  // group_end
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dnc_pkg::COUNT_BITS-1:0]  m_axis_tdata,  // [31:0] running_count
    output logic                            m_axis_tuser,  // [0] deficient
    output logic                            m_axis_tlast   // group_done
);
    import dnc_pkg::*;

    logic [VALUE_BITS-1:0] w_number;
    logic                  w_start;
    logic                  w_take;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [VALUE_BITS-1:0] w_dividend;
    logic [VALUE_BITS-1:0] w_divisor;
    logic [VALUE_BITS-1:0] w_quotient;
    logic [VALUE_BITS-1:0] w_remainder;
    t_seq_stat             w_stat;
    logic [TALLY_BITS-1:0] w_tally_inc;
    logic [63:0]           w_tally_ext;

    logic [TALLY_BITS-1:0] r_tally;
    logic                  r_m_valid;
    logic                  r_m_def;
    logic                  r_m_last;
    logic [COUNT_BITS-1:0] r_m_count;

    generate
        if (VALUE_BITS <= NUM_BITS) begin : g_narrow
            assign w_number = s_axis_tdata[VALUE_BITS-1:0];
        end else begin : g_wide
            assign w_number = {{(VALUE_BITS-NUM_BITS){s_axis_tdata[NUM_BITS-1]}}, s_axis_tdata};
        end
    endgenerate

    assign s_axis_tready = w_stat.idle;
    assign w_start       = s_axis_tvalid && w_stat.idle;
    assign w_take        = w_stat.valid && (!r_m_valid || m_axis_tready);

    dnc_seq #(
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_number    (w_number),
        .i_last      (s_axis_tlast),
        .i_take      (w_take),
        .i_div_done  (w_div_done),
        .i_quotient  (w_quotient),
        .i_remainder (w_remainder),
        .o_div_start (w_div_start),
        .o_dividend  (w_dividend),
        .o_divisor   (w_divisor),
        .o_stat      (w_stat)
    );

    dnc_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quotient),
        .o_remainder (w_remainder)
    );

    // saturate the tally at all ones
    assign w_tally_inc = (w_stat.deficient && (r_tally != '1)) ? r_tally + 1'b1 : r_tally;
    assign w_tally_ext = 64'(w_tally_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_m_valid <= 1'b1;
                r_tally   <= w_stat.last ? '0 : w_tally_inc;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_m_def   <= w_stat.deficient;
            r_m_last  <= w_stat.last;
            r_m_count <= w_tally_ext[COUNT_BITS-1:0];
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_count;
    assign m_axis_tuser  = r_m_def;
    assign m_axis_tlast  = r_m_last;

    a_idle_no_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.idle |-> !w_stat.valid)
        else $error("sequencer idle while holding a result");

    a_group_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_stat.last) |=> (r_tally == '0))
        else $error("tally not cleared after group end");

    a_def_counts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_stat.deficient) |=> (r_m_def && (r_tally != '0 || r_m_last)))
        else $error("deficient result did not advance the tally");

endmodule

>>> tb/tb_deficient_number_counter.sv
module tb_deficient_number_counter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NUM_W       = dnc_pkg::NUM_BITS;
    localparam int          CNT_W       = dnc_pkg::COUNT_BITS;
    localparam int          RAND_ITEMS  = 100;
    localparam int          CALM_ITEMS  = 20;
    localparam int          DRAIN_WAIT  = 64;
    localparam int unsigned CYCLE_LIMIT = 16_000_000;

    typedef struct {
        logic [NUM_W-1:0] number;
        logic             group_end;
        logic             calm;      // no idling on either side from here on
    } t_number_item;

    typedef struct {
        logic             deficient;
        logic [CNT_W-1:0] running_count;
        logic             group_done;
    } t_verdict;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             s_axis_tvalid  = 1'b0;
    logic             s_axis_tready;
    logic [NUM_W-1:0] s_axis_tdata   = '0;  // [31:0] number
    logic             s_axis_tlast   = 1'b0; // group_end
    logic             m_axis_tvalid;
    logic             m_axis_tready  = 1'b0;
    logic [CNT_W-1:0] m_axis_tdata;         // [31:0] running_count
    logic             m_axis_tuser;         // [0] deficient
    logic             m_axis_tlast;         // group_done

    t_number_item     pending_numbers[$];
    t_verdict         verdicts_due[$];
    t_number_item     cur_number;
    logic [CNT_W-1:0] open_tally     = '0;
    logic             calm_phase     = 1'b0;
    int unsigned      src_gap        = 0;
    int unsigned      sink_gap       = 0;
    int unsigned      cycle_count    = 0;
    int unsigned      error_count    = 0;
    int unsigned      checked_count  = 0;
    int unsigned      deficient_seen = 0;
    int unsigned      groups_closed  = 0;

    deficient_number_counter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Aliquot-sum test; trials reports how many divisors the search visits,
    // which tracks the time the block needs for the value.
    function automatic logic predict_verdict(input logic [NUM_W-1:0] raw,
                                             output int unsigned trials);
        longint unsigned n;
        longint unsigned acc;
        longint unsigned d;
        longint unsigned q;
        trials = 0;
        if (raw == '0 || raw[NUM_W-1]) begin
            return 1'b0;
        end
        n   = raw;
        acc = (n > 1) ? 1 : 0;
        for (d = 2; d * d <= n; d++) begin
            trials++;
            if (n % d == 0) begin
                q   = n / d;
                acc += d;
                if (q != d) begin
                    acc += q;
                end
                if (acc >= n) begin
                    return 1'b0;
                end
            end
        end
        return acc < n;
    endfunction

    task automatic queue_number(input logic [NUM_W-1:0] number, input logic group_end,
                                input logic calm);
        t_number_item item;
        item.number    = number;
        item.group_end = group_end;
        item.calm      = calm;
        pending_numbers.push_back(item);
    endtask

    task automatic wait_all_returned();
        while (pending_numbers.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Driver: predict on every accepted transaction, then load the next number
    always @(posedge i_clk) begin
        int unsigned trials;
        t_verdict    verdict;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                verdict.deficient = predict_verdict(cur_number.number, trials);
                if (verdict.deficient && open_tally != '1) begin
                    open_tally = open_tally + 1'b1;
                end
                verdict.running_count = open_tally;
                verdict.group_done    = cur_number.group_end;
                if (cur_number.group_end) begin
                    open_tally = '0;
                end
                verdicts_due.push_back(verdict);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap       <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_numbers.size() != 0) begin
                    cur_number     = pending_numbers.pop_front();
                    calm_phase    <= cur_number.calm;
                    s_axis_tdata  <= cur_number.number;
                    s_axis_tlast  <= cur_number.group_end;
                    s_axis_tvalid <= 1'b1;
                    if (!cur_number.calm && $urandom_range(0, 3) == 0) begin
                        src_gap <= $urandom_range(1, 16);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result with nothing outstanding: count=%0d", m_axis_tdata);
                    error_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    checked_count++;
                    if (m_axis_tuser) deficient_seen++;
                    if (m_axis_tlast) groups_closed++;
                    if (m_axis_tuser !== want.deficient) begin
                        $error("deficient: expected %0b, got %0b",
                               want.deficient, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata !== want.running_count) begin
                        $error("running_count: expected %0d, got %0d",
                               want.running_count, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.group_done) begin
                        $error("group_done: expected %0b, got %0b",
                               want.group_done, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            if (sink_gap != 0) begin
                sink_gap      <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm_phase && $urandom_range(0, 5) == 0) begin
                    sink_gap <= $urandom_range(1, 16);
                end
            end
        end
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("deficient_number_counter regression: fail");
        $finish;
    end

    initial begin
        logic [NUM_W-1:0] value;
        int unsigned      trials;
        int unsigned      tries;
        logic             calm;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero, one, negatives, perfect, squares, odd abundant, field extremes
        queue_number(32'd0,          1'b0, 1'b0);
        queue_number(32'd1,          1'b0, 1'b0);
        queue_number(32'd2,          1'b0, 1'b0);
        queue_number(32'd4,          1'b0, 1'b0);
        queue_number(32'd6,          1'b0, 1'b0);
        queue_number(32'd9,          1'b0, 1'b0);
        queue_number(32'd12,         1'b1, 1'b0);
        queue_number(32'hFFFF_FFFF,  1'b0, 1'b0);
        queue_number(32'h8000_0000,  1'b0, 1'b0);
        queue_number(32'd25,         1'b0, 1'b0);
        queue_number(32'd28,         1'b0, 1'b0);
        queue_number(32'd945,        1'b0, 1'b0);
        queue_number(32'd16,         1'b1, 1'b0);
        queue_number(32'd1,          1'b1, 1'b0);
        queue_number(32'd0,          1'b1, 1'b0);
        queue_number(32'd2147483640, 1'b0, 1'b0);
        queue_number(32'h7FFF_FFFF,  1'b0, 1'b0);
        queue_number(32'd8128,       1'b0, 1'b0);
        queue_number(32'd7,          1'b1, 1'b0);

        // Hold the sender until the pipeline is empty
        wait_all_returned();

        for (int k = 0; k < RAND_ITEMS; k++) begin
            calm = (k >= RAND_ITEMS - CALM_ITEMS);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: value = $urandom_range(0, 1023);
                4, 5:       value = $urandom_range(1, 262143);
                6, 7:       value = $urandom | 32'h8000_0000;
                default: begin
                    // Large positive values; keep only those that stop early
                    tries = 0;
                    do begin
                        value = $urandom & 32'h7FFF_FFFF;
                        void'(predict_verdict(value, trials));
                        tries++;
                    end while (trials > 300 && tries < 4);
                    if (trials > 300) begin
                        value = 32'd12 * $urandom_range(1, 178956970);
                    end
                end
            endcase
            queue_number(value, ($urandom_range(0, 7) == 0), calm);
        end
        queue_number($urandom_range(0, 1023), 1'b1, 1'b1);

        wait_all_returned();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("checked %0d results: %0d deficient, %0d groups closed",
                 checked_count, deficient_seen, groups_closed);
        $display("covered zero, one, negatives, perfect and abundant values, squares, %s",
                 "the largest prime and random values under random stalls");
        if (error_count == 0 && verdicts_due.size() == 0) begin
            $display("deficient_number_counter regression: pass");
        end else begin
            $display("deficient_number_counter regression: fail");
        end
        $finish;
    end

endmodule
